@@ rtl/vnpf_pkg.sv @@
// shared types, grammar step codes and field ids for the nal field parser
package vnpf_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW = 2;

   typedef enum logic [5:0] {
      G_IDLE = 6'd0,
      G_VPS_ID, G_VPS_LAYERS, G_VPS_SUB,
      G_SPS_ID, G_SPS_VPS, G_SPS_SUB, G_SPS_CHROMA, G_SPS_CTU,
      G_SPS_X1, G_SPS_X2, G_SPS_X3, G_SPS_RPR, G_SPS_RPRX,
      G_SPS_MAXW, G_SPS_MAXH, G_SPS_CONF,
      G_SPS_L, G_SPS_R, G_SPS_T, G_SPS_B,
      G_SPS_SUBPIC, G_SPS_NSUB, G_SPS_BD,
      G_PPS_ID, G_PPS_SPS, G_PPS_X, G_PPS_W, G_PPS_H,
      G_PH_F1, G_PH_F2, G_PH_F3, G_PH_F4, G_PH_F5, G_PH_PPS, G_PH_POC,
      G_SH
   } step_type;

   localparam logic [5:0] ID_END = 6'd39;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_HDR_TRUNC = 2'd1;
   localparam logic [1:0] ST_PAY_TRUNC = 2'd2;
   localparam logic [1:0] ST_EG_OVF = 2'd3;

   // byte class decided by the front part
   typedef enum logic [1:0] {
      K_HDR0 = 2'd0,
      K_HDR1 = 2'd1,
      K_PAYLOAD = 2'd2,
      K_DROP = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type kind;
      logic [7:0] data;
      logic last;
   } entry_type;

   typedef struct packed {
      logic [5:0] id;
      logic [31:0] value;
      logic last;
      logic [1:0] status;
   } rec_type;

   // 1..8 for a fixed-width read, 0 for ue
   function automatic logic [3:0] step_width(input step_type s);
      logic [3:0] w;
      case (s)
         G_VPS_ID, G_SPS_ID, G_SPS_VPS, G_PPS_SPS: w = 4'd4;
         G_VPS_LAYERS, G_PPS_ID: w = 4'd6;
         G_VPS_SUB, G_SPS_SUB: w = 4'd3;
         G_SPS_CHROMA, G_SPS_CTU: w = 4'd2;
         G_SPS_MAXW, G_SPS_MAXH, G_SPS_L, G_SPS_R, G_SPS_T, G_SPS_B,
         G_SPS_NSUB, G_SPS_BD, G_PPS_W, G_PPS_H, G_PH_PPS: w = 4'd0;
         G_PH_POC: w = 4'd8;
         default: w = 4'd1;
      endcase
      return w;
   endfunction

   function automatic step_type first_step(input logic [4:0] t);
      step_type s;
      case (t)
         5'd14: s = G_VPS_ID;
         5'd15: s = G_SPS_ID;
         5'd16: s = G_PPS_ID;
         5'd19: s = G_PH_F1;
         default: s = (t <= 5'd11) ? G_SH : G_IDLE;
      endcase
      return s;
   endfunction

endpackage

@@ rtl/vnpf_front.sv @@
// front part: header byte counting and emulation prevention classification
module vnpf_front (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  logic [7:0] in_byte,
   input  logic in_last,
   output logic in_ready,
   output logic q_push,
   output vnpf_pkg::entry_type q_entry,
   input  logic q_full
);
   logic [1:0] hdr_cnt_ff, hdr_cnt_in;
   logic [1:0] zero_run_ff, zero_run_in;
   logic take;

   assign in_ready = !q_full;
   assign take = in_valid && !q_full;
   assign q_push = take;

   always_comb begin
      hdr_cnt_in = hdr_cnt_ff;
      zero_run_in = zero_run_ff;
      q_entry.data = in_byte;
      q_entry.last = in_last;
      if (hdr_cnt_ff == 2'd0) begin
         q_entry.kind = vnpf_pkg::K_HDR0;
      end else if (hdr_cnt_ff == 2'd1) begin
         q_entry.kind = vnpf_pkg::K_HDR1;
      end else if (zero_run_ff == 2'd2 && in_byte == 8'h03) begin
         q_entry.kind = vnpf_pkg::K_DROP;
      end else begin
         q_entry.kind = vnpf_pkg::K_PAYLOAD;
      end
      if (take) begin
         if (hdr_cnt_ff != 2'd2) begin
            hdr_cnt_in = hdr_cnt_ff + 2'd1;
         end else if (q_entry.kind == vnpf_pkg::K_DROP || in_byte != 8'h00) begin
            zero_run_in = 2'd0;
         end else if (zero_run_ff != 2'd2) begin
            zero_run_in = zero_run_ff + 2'd1;
         end
         if (in_last) begin
            hdr_cnt_in = 2'd0;
            zero_run_in = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_cnt_ff <= 2'd0;
         zero_run_ff <= 2'd0;
      end else begin
         hdr_cnt_ff <= hdr_cnt_in;
         zero_run_ff <= zero_run_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      hdr_cnt_ff != 2'd3)
      else $error("header count out of range");
   assert property (@(posedge clock) disable iff (reset)
      (take && in_last) |=> hdr_cnt_ff == 2'd0)
      else $error("header count not cleared at unit end");
   assert property (@(posedge clock) disable iff (reset)
      (q_push && q_entry.kind == vnpf_pkg::K_DROP) |-> hdr_cnt_ff == 2'd2)
      else $error("drop inside header");
endmodule

@@ rtl/vnpf_fifo.sv @@
// short entry queue between front and back
module vnpf_fifo (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  vnpf_pkg::entry_type wdata,
   output logic full,
   input  logic pop,
   output vnpf_pkg::entry_type rdata,
   output logic empty
);
   vnpf_pkg::entry_type mem_ff [vnpf_pkg::FIFO_DEPTH];
   logic [vnpf_pkg::FIFO_AW-1:0] wp_ff, rp_ff;
   logic [vnpf_pkg::FIFO_AW:0] cnt_ff;
   logic do_push, do_pop;

   assign full = cnt_ff == (vnpf_pkg::FIFO_AW+1)'(vnpf_pkg::FIFO_DEPTH);
   assign empty = cnt_ff == '0;
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign rdata = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wp_ff] <= wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) wp_ff <= wp_ff + 1'b1;
         if (do_pop) rp_ff <= rp_ff + 1'b1;
         if (do_push && !do_pop) cnt_ff <= cnt_ff + 1'b1;
         else if (do_pop && !do_push) cnt_ff <= cnt_ff - 1'b1;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (vnpf_pkg::FIFO_AW+1)'(vnpf_pkg::FIFO_DEPTH))
      else $error("queue count overflow");
   assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("queue count not advanced");
   assert property (@(posedge clock) disable iff (reset)
      (wp_ff == rp_ff) |-> (empty || full))
      else $error("pointer and count disagree");
endmodule

@@ rtl/vnpf_back.sv @@
// back part: bit serial grammar walk, one bit or one record per cycle while the receiver takes records
module vnpf_back (
   input  logic clock,
   input  logic reset,
   input  logic q_empty,
   input  vnpf_pkg::entry_type q_entry,
   output logic q_pop,
   output logic rec_valid,
   output vnpf_pkg::rec_type rec,
   input  logic rec_ready
);
   // pending record slots: a finished read may emit up to three records
   vnpf_pkg::rec_type pend_ff [3], pend_in [3];
   logic [1:0] npend_ff, npend_in;
   logic [1:0] pidx_ff, pidx_in;

   logic [7:0] fhb_ff, fhb_in;
   vnpf_pkg::step_type step_ff, step_in;
   logic [31:0] acc_ff, acc_in;
   logic [5:0] bcnt_ff, bcnt_in;
   logic gph_ff, gph_in;
   logic [4:0] csub_ff, csub_in;
   logic [31:0] sz_ff [6], sz_in [6];
   logic done_ff, done_in;
   logic [1:0] pst_ff, pst_in;
   logic [2:0] bit_ff, bit_in;      // next bit index, counts down
   logic busy_ff, busy_in;          // a payload byte is being shifted
   logic [7:0] byte_ff, byte_in;
   logic blast_ff, blast_in;
   logic endp_ff, endp_in;          // end record owed after this byte
   // cropped size is computed in its own step from the registered sizes: sum then scale/subtract
   logic crop_ff, crop_in;
   // keyframe flag waits until the first three header records are out
   logic kf_ff, kf_in, kfp_ff, kfp_in;

   logic b;
   logic [3:0] w;
   logic fin;
   logic [31:0] fv;
   logic [1:0] sx_sh, sy_sh;
   logic [31:0] suml, sumt;

   function automatic vnpf_pkg::rec_type mk(input logic [5:0] i, input logic [31:0] v);
      vnpf_pkg::rec_type r;
      r.id = i;
      r.value = v;
      r.last = 1'b0;
      r.status = vnpf_pkg::ST_OK;
      return r;
   endfunction

   assign rec_valid = npend_ff != 2'd0;
   assign rec = pend_ff[pidx_ff];
   assign b = byte_ff[bit_ff];
   assign w = vnpf_pkg::step_width(step_ff);

   always_comb begin
      sx_sh = (csub_ff[4:3] == 2'd1 || csub_ff[4:3] == 2'd2) ? 2'd1 : 2'd0;
      sy_sh = (csub_ff[4:3] == 2'd1) ? 2'd1 : 2'd0;
      suml = sz_ff[2] + sz_ff[3];
      sumt = sz_ff[4] + sz_ff[5];
   end

   always_comb begin
      npend_in = npend_ff;
      pidx_in = pidx_ff;
      for (int i = 0; i < 3; i++) pend_in[i] = pend_ff[i];
      for (int i = 0; i < 6; i++) sz_in[i] = sz_ff[i];
      fhb_in = fhb_ff;
      step_in = step_ff;
      acc_in = acc_ff;
      bcnt_in = bcnt_ff;
      gph_in = gph_ff;
      csub_in = csub_ff;
      done_in = done_ff;
      pst_in = pst_ff;
      bit_in = bit_ff;
      busy_in = busy_ff;
      byte_in = byte_ff;
      blast_in = blast_ff;
      endp_in = endp_ff;
      crop_in = crop_ff;
      kf_in = kf_ff;
      kfp_in = kfp_ff;
      q_pop = 1'b0;
      fin = 1'b0;
      fv = '0;

      if (npend_ff != 2'd0) begin
         // drain records first
         if (rec_ready) begin
            if (pidx_ff == npend_ff - 2'd1) begin
               npend_in = 2'd0;
               pidx_in = 2'd0;
            end else begin
               pidx_in = pidx_ff + 2'd1;
            end
         end
      end else if (kfp_ff) begin
         // keyframe record rides as the fourth header record
         pend_in[0] = mk(6'd3, {31'd0, kf_ff});
         npend_in = 2'd1;
         kfp_in = 1'b0;
      end else if (crop_ff) begin
         crop_in = 1'b0;
         pend_in[0] = mk(6'd21, sz_ff[0] - (suml << sx_sh));
         pend_in[1] = mk(6'd22, sz_ff[1] - (sumt << sy_sh));
         npend_in = 2'd2;
      end else if (busy_ff) begin
         if (done_ff) begin
            busy_in = 1'b0;
         end else begin
            if (w != 4'd0) begin
               acc_in = {acc_ff[30:0], b};
               bcnt_in = bcnt_ff + 6'd1;
               if ({2'b00, bcnt_in} >= {4'd0, w}) begin
                  fin = 1'b1;
                  fv = acc_in;
                  acc_in = '0;
                  bcnt_in = '0;
               end
            end else if (!gph_ff) begin
               if (!b) begin
                  bcnt_in = bcnt_ff + 6'd1;
                  if (bcnt_in >= 6'(vnpf_pkg::VALUE_WIDTH)) begin
                     pst_in = vnpf_pkg::ST_EG_OVF;
                     done_in = 1'b1;
                     step_in = vnpf_pkg::G_IDLE;
                  end
               end else if (bcnt_ff == '0) begin
                  fin = 1'b1;
               end else begin
                  gph_in = 1'b1;
                  acc_in = 32'd1;
               end
            end else begin
               acc_in = {acc_ff[30:0], b};
               bcnt_in = bcnt_ff - 6'd1;
               if (bcnt_in == '0) begin
                  fin = 1'b1;
                  fv = acc_in - 32'd1;
                  gph_in = 1'b0;
                  acc_in = '0;
               end
            end
            if (bit_ff == 3'd0) busy_in = 1'b0;
            bit_in = bit_ff - 3'd1;
         end
      end else if (endp_ff) begin
         endp_in = 1'b0;
         pend_in[0].id = vnpf_pkg::ID_END;
         pend_in[0].value = '0;
         pend_in[0].last = 1'b1;
         if (!blast_ff) pend_in[0].status = vnpf_pkg::ST_HDR_TRUNC;
         else if (done_ff) pend_in[0].status = pst_ff;
         else if (step_ff == vnpf_pkg::G_PH_POC) pend_in[0].status = vnpf_pkg::ST_OK;
         else pend_in[0].status = vnpf_pkg::ST_PAY_TRUNC;
         npend_in = 2'd1;
         // back to reset state
         blast_in = 1'b0;
         step_in = vnpf_pkg::G_IDLE;
         acc_in = '0; bcnt_in = '0; gph_in = 1'b0; csub_in = '0;
         for (int i = 0; i < 6; i++) sz_in[i] = '0;
         done_in = 1'b0; pst_in = vnpf_pkg::ST_OK; fhb_in = '0;
      end else if (!q_empty) begin
         q_pop = 1'b1;
         endp_in = q_entry.last;
         case (q_entry.kind)
            vnpf_pkg::K_HDR0: fhb_in = q_entry.data;
            vnpf_pkg::K_HDR1: begin
               blast_in = 1'b1;   // header complete
               pend_in[0] = mk(6'd0, {27'd0, fhb_ff[7:3]});
               pend_in[1] = mk(6'd1, {26'd0, fhb_ff[2:0], q_entry.data[7:5]});
               pend_in[2] = mk(6'd2, {29'd0, q_entry.data[2:0]});
               npend_in = 2'd3;
               step_in = vnpf_pkg::first_step(fhb_ff[7:3]);
               if (step_in == vnpf_pkg::G_IDLE) done_in = 1'b1;
               kf_in = (fhb_ff[7:3] >= 5'd7 && fhb_ff[7:3] <= 5'd10);
               kfp_in = 1'b1;
            end
            vnpf_pkg::K_PAYLOAD: begin
               byte_in = q_entry.data;
               bit_in = 3'd7;
               busy_in = 1'b1;
            end
            default: ;
         endcase
      end

      if (fin) begin
         case (step_ff)
            vnpf_pkg::G_VPS_ID: begin pend_in[0] = mk(6'd4, fv); npend_in = 2'd1;
               step_in = vnpf_pkg::G_VPS_LAYERS; end
            vnpf_pkg::G_VPS_LAYERS: begin pend_in[0] = mk(6'd5, fv); npend_in = 2'd1;
               step_in = vnpf_pkg::G_VPS_SUB; end
            vnpf_pkg::G_VPS_SUB: begin pend_in[0] = mk(6'd6, fv); npend_in = 2'd1;
               done_in = 1'b1; step_in = vnpf_pkg::G_IDLE; end
            vnpf_pkg::G_SPS_ID: begin pend_in[0] = mk(6'd7, fv); npend_in = 2'd1;
               step_in = vnpf_pkg::G_SPS_VPS; end
            vnpf_pkg::G_SPS_VPS: begin pend_in[0] = mk(6'd8, fv); npend_in = 2'd1;
               step_in = vnpf_pkg::G_SPS_SUB; end
            vnpf_pkg::G_SPS_SUB: begin csub_in[2:0] = fv[2:0];
               pend_in[0] = mk(6'd9, fv); npend_in = 2'd1;
               step_in = vnpf_pkg::G_SPS_CHROMA; end
            vnpf_pkg::G_SPS_CHROMA: begin csub_in[4:3] = fv[1:0];
               pend_in[0] = mk(6'd10, fv); npend_in = 2'd1;
               step_in = vnpf_pkg::G_SPS_CTU; end
            vnpf_pkg::G_SPS_CTU: begin
               pend_in[0] = mk(6'd11, fv);
               pend_in[1] = mk(6'd12, 32'd1 << ({3'd0, fv[1:0]} + 5'd5));
               npend_in = 2'd2; step_in = vnpf_pkg::G_SPS_X1; end
            vnpf_pkg::G_SPS_X1: step_in = (csub_ff[2:0] != 3'd0) ?
               vnpf_pkg::G_SPS_X2 : vnpf_pkg::G_SPS_X3;
            vnpf_pkg::G_SPS_X2: step_in = vnpf_pkg::G_SPS_X3;
            vnpf_pkg::G_SPS_X3: step_in = vnpf_pkg::G_SPS_RPR;
            vnpf_pkg::G_SPS_RPR: begin pend_in[0] = mk(6'd13, fv); npend_in = 2'd1;
               step_in = fv[0] ? vnpf_pkg::G_SPS_RPRX : vnpf_pkg::G_SPS_MAXW; end
            vnpf_pkg::G_SPS_RPRX: step_in = vnpf_pkg::G_SPS_MAXW;
            vnpf_pkg::G_SPS_MAXW: begin sz_in[0] = fv; pend_in[0] = mk(6'd14, fv);
               npend_in = 2'd1; step_in = vnpf_pkg::G_SPS_MAXH; end
            vnpf_pkg::G_SPS_MAXH: begin sz_in[1] = fv; pend_in[0] = mk(6'd15, fv);
               npend_in = 2'd1; step_in = vnpf_pkg::G_SPS_CONF; end
            vnpf_pkg::G_SPS_CONF: begin
               pend_in[0] = mk(6'd16, fv); npend_in = 2'd1;
               if (fv[0]) step_in = vnpf_pkg::G_SPS_L;
               else begin
                  for (int i = 2; i < 6; i++) sz_in[i] = '0;
                  crop_in = 1'b1; step_in = vnpf_pkg::G_SPS_SUBPIC;
               end
            end
            vnpf_pkg::G_SPS_L: begin sz_in[2] = fv; pend_in[0] = mk(6'd17, fv);
               npend_in = 2'd1; step_in = vnpf_pkg::G_SPS_R; end
            vnpf_pkg::G_SPS_R: begin sz_in[3] = fv; pend_in[0] = mk(6'd18, fv);
               npend_in = 2'd1; step_in = vnpf_pkg::G_SPS_T; end
            vnpf_pkg::G_SPS_T: begin sz_in[4] = fv; pend_in[0] = mk(6'd19, fv);
               npend_in = 2'd1; step_in = vnpf_pkg::G_SPS_B; end
            vnpf_pkg::G_SPS_B: begin sz_in[5] = fv; pend_in[0] = mk(6'd20, fv);
               npend_in = 2'd1; crop_in = 1'b1; step_in = vnpf_pkg::G_SPS_SUBPIC; end
            vnpf_pkg::G_SPS_SUBPIC: step_in = fv[0] ? vnpf_pkg::G_SPS_NSUB :
               vnpf_pkg::G_SPS_BD;
            vnpf_pkg::G_SPS_NSUB: begin pend_in[0] = mk(6'd23, fv); npend_in = 2'd1;
               step_in = vnpf_pkg::G_SPS_BD; end
            vnpf_pkg::G_SPS_BD: begin pend_in[0] = mk(6'd24, fv);
               pend_in[1] = mk(6'd25, fv + 32'd8); npend_in = 2'd2;
               done_in = 1'b1; step_in = vnpf_pkg::G_IDLE; end
            vnpf_pkg::G_PPS_ID: begin pend_in[0] = mk(6'd26, fv); npend_in = 2'd1;
               step_in = vnpf_pkg::G_PPS_SPS; end
            vnpf_pkg::G_PPS_SPS: begin pend_in[0] = mk(6'd27, fv); npend_in = 2'd1;
               step_in = vnpf_pkg::G_PPS_X; end
            vnpf_pkg::G_PPS_X: step_in = vnpf_pkg::G_PPS_W;
            vnpf_pkg::G_PPS_W: begin sz_in[0] = fv; pend_in[0] = mk(6'd28, fv);
               npend_in = 2'd1; step_in = vnpf_pkg::G_PPS_H; end
            vnpf_pkg::G_PPS_H: begin pend_in[0] = mk(6'd29, fv);
               pend_in[1] = mk(6'd21, sz_ff[0]); pend_in[2] = mk(6'd22, fv);
               npend_in = 2'd3; done_in = 1'b1; step_in = vnpf_pkg::G_IDLE; end
            vnpf_pkg::G_PH_F1, vnpf_pkg::G_PH_F2, vnpf_pkg::G_PH_F3,
            vnpf_pkg::G_PH_F4, vnpf_pkg::G_PH_F5: begin
               pend_in[0] = mk(6'd30 + (step_ff - 6'(vnpf_pkg::G_PH_F1)), fv);
               npend_in = 2'd1;
               step_in = vnpf_pkg::step_type'(step_ff + 6'd1); end
            vnpf_pkg::G_PH_PPS: begin pend_in[0] = mk(6'd35, fv); npend_in = 2'd1;
               step_in = vnpf_pkg::G_PH_POC; end
            vnpf_pkg::G_PH_POC: begin pend_in[0] = mk(6'd36, fv);
               pend_in[1] = mk(6'd37, fv); npend_in = 2'd2;
               done_in = 1'b1; step_in = vnpf_pkg::G_IDLE; end
            vnpf_pkg::G_SH: begin pend_in[0] = mk(6'd38, fv); npend_in = 2'd1;
               done_in = 1'b1; step_in = vnpf_pkg::G_IDLE; end
            default: begin done_in = 1'b1; step_in = vnpf_pkg::G_IDLE; end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) pend_ff[i] <= pend_in[i];
      byte_ff <= byte_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         npend_ff <= '0; pidx_ff <= '0;
         step_ff <= vnpf_pkg::G_IDLE;
         acc_ff <= '0; fhb_ff <= '0; kf_ff <= 1'b0;
         for (int i = 0; i < 6; i++) sz_ff[i] <= '0;
         bcnt_ff <= '0; gph_ff <= 1'b0; csub_ff <= '0;
         done_ff <= 1'b0; pst_ff <= vnpf_pkg::ST_OK;
         bit_ff <= '0; busy_ff <= 1'b0; blast_ff <= 1'b0;
         endp_ff <= 1'b0; crop_ff <= 1'b0; kfp_ff <= 1'b0;
      end else begin
         npend_ff <= npend_in; pidx_ff <= pidx_in;
         step_ff <= step_in;
         acc_ff <= acc_in; fhb_ff <= fhb_in; kf_ff <= kf_in;
         for (int i = 0; i < 6; i++) sz_ff[i] <= sz_in[i];
         bcnt_ff <= bcnt_in; gph_ff <= gph_in; csub_ff <= csub_in;
         done_ff <= done_in; pst_ff <= pst_in;
         bit_ff <= bit_in; busy_ff <= busy_in; blast_ff <= blast_in;
         endp_ff <= endp_in; crop_ff <= crop_in; kfp_ff <= kfp_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      npend_ff != 2'd0 |-> pidx_ff < npend_ff)
      else $error("record index past pending count");
   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (npend_ff == 2'd0 && !busy_ff && !crop_ff && !endp_ff && !kfp_ff))
      else $error("queue popped while busy");
   assert property (@(posedge clock) disable iff (reset)
      done_ff |-> step_ff == vnpf_pkg::G_IDLE)
      else $error("step left after parse end");
endmodule

@@ rtl/video_nal_parameter_field_parser.sv @@
// top level of the nal header and parameter field parser
// usage:
//  - input side is a queue: drive req_nal_byte and req_last_byte with push,
//    the item is taken when push is high and full is low
//  - result side is a queue: while empty is low, rsp_* hold the oldest record,
//    pop takes it
//  - the front part counts header bytes and flags emulation prevention bytes,
//    then drops the item into a four-entry queue
//  - the back part walks the grammar one payload bit per cycle while the
//    receiver takes records: a payload byte is loaded, then shifted bit by
//    bit; each record and a cropped size pair take a step each; after the
//    parse end a byte is loaded and discarded; a first header byte or dropped
//    byte is only popped; the second header byte: load, three records, keyframe
//  - after the last byte the unit-end record is built, then popped
//  - records leave through a pending slot set; the back part stalls while the
//    receiver holds pop low, and the front queue then fills and raises full
//  - synchronous reset clears all control state; the block is ready the
//    cycle after reset drops
module video_nal_parameter_field_parser (
   input  logic clock,
   input  logic reset,
   input  logic push,
   output logic full,
   input  logic [7:0] req_nal_byte,
   input  logic req_last_byte,
   output logic empty,
   input  logic pop,
   output logic [5:0] rsp_field_id,
   output logic [31:0] rsp_field_value,
   output logic rsp_last_record,
   output logic [1:0] rsp_status
);
   logic in_ready;
   logic q_push, q_full, q_pop, q_empty;
   vnpf_pkg::entry_type q_wdata, q_rdata;
   logic rec_valid;
   vnpf_pkg::rec_type rec;

   assign full = !in_ready;

   vnpf_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(push), .in_byte(req_nal_byte), .in_last(req_last_byte),
      .in_ready(in_ready), .q_push(q_push), .q_entry(q_wdata), .q_full(q_full)
   );

   vnpf_fifo u_fifo (
      .clock(clock), .reset(reset),
      .push(q_push), .wdata(q_wdata), .full(q_full),
      .pop(q_pop), .rdata(q_rdata), .empty(q_empty)
   );

   vnpf_back u_back (
      .clock(clock), .reset(reset),
      .q_empty(q_empty), .q_entry(q_rdata), .q_pop(q_pop),
      .rec_valid(rec_valid), .rec(rec), .rec_ready(pop)
   );

   // records come straight from the pending slots
   assign empty = !rec_valid;
   assign rsp_field_id = rec.id;
   assign rsp_field_value = rec.value;
   assign rsp_last_record = rec.last;
   assign rsp_status = rec.status;

   assert property (@(posedge clock) disable iff (reset)
      rsp_last_record && !empty |-> rsp_field_id == vnpf_pkg::ID_END)
      else $error("last record without end id");
   assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_field_id != vnpf_pkg::ID_END) |-> rsp_status == vnpf_pkg::ST_OK)
      else $error("status on a field record");
   assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_field_id == vnpf_pkg::ID_END) |-> rsp_field_value == '0)
      else $error("end record carries a value");
endmodule
